>>> hw/rtl/dnle_pkg.sv
// shared types and constants of the dns name label encoder
package dnle_pkg;

    localparam int STORE_DEPTH = 63;
    localparam int COUNT_W     = 6;
    localparam int LENGTH_W    = 9;

    localparam int MAX_LABEL = 63;
    localparam logic [COUNT_W-1:0]  LABEL_LIMIT  = COUNT_W'(MAX_LABEL);
    localparam logic [LENGTH_W-1:0] LENGTH_LIMIT = 9'd511;
    localparam logic [7:0]          SEPARATOR    = 8'h2E;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } dnle_state_t;

    typedef struct packed {
        logic store_char;
        logic start_run;
        logic load_octet;
    } dnle_cmd_t;

    typedef struct packed {
        logic run_item;
        logic out_free;
        logic last_octet;
    } dnle_status_t;

endpackage

>>> hw/rtl/dnle_in_if.sv
// character channel of the encoder
interface dnle_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] octet;

    modport source (output valid, output mode, output octet, input ready);
    modport sink (input valid, input mode, input octet, output ready);
endinterface

>>> hw/rtl/dnle_out_if.sv
// encoded octet channel of the encoder
interface dnle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_octet;
    logic       run_last;
    logic       name_end;
    logic [8:0] name_length;
    logic       label_overflow;

    modport source (output valid, output out_octet, output run_last, output name_end,
                    output name_length, output label_overflow, input ready);
    modport sink (input valid, input out_octet, input run_last, input name_end,
                  input name_length, input label_overflow, output ready);
endinterface

>>> hw/rtl/dnle_datapath.sv
// label store, length counters and output register
module dnle_datapath
    import dnle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mode,
    input  logic [7:0]       octet,
    input  dnle_cmd_t        cmd,
    output dnle_status_t     status,
    dnle_out_if.source       octets
);

    logic [7:0]          store_mem [STORE_DEPTH];
    logic [7:0]          rd_data_reg;

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [LENGTH_W-1:0] total_reg, total_next;
    logic                overflow_reg, overflow_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic                at_end_reg;
    logic [LENGTH_W-1:0] run_total_reg;
    logic [LENGTH_W-1:0] name_len_reg;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_octet_reg;
    logic                out_last_reg;
    logic                out_end_reg;
    logic [LENGTH_W-1:0] out_len_reg;
    logic                out_ovf_reg;

    logic [LENGTH_W:0]   label_sum;
    logic [LENGTH_W-1:0] total_sat;
    logic [LENGTH_W:0]   name_sum;
    logic [LENGTH_W-1:0] name_sat;
    logic                last_octet;

    assign label_sum = {1'b0, total_reg} + (LENGTH_W+1)'(count_reg) + 10'd1;
    assign total_sat = (label_sum > {1'b0, LENGTH_LIMIT}) ? LENGTH_LIMIT
                                                          : label_sum[LENGTH_W-1:0];
    assign name_sum  = {1'b0, total_sat} + 10'd1;
    assign name_sat  = (name_sum > {1'b0, LENGTH_LIMIT}) ? LENGTH_LIMIT
                                                        : name_sum[LENGTH_W-1:0];

    assign last_octet = (idx_reg == count_reg);

    assign status.run_item   = (mode == MODE_END) || (octet == SEPARATOR);
    assign status.out_free   = !out_valid_reg || octets.ready;
    assign status.last_octet = last_octet;

    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        overflow_next  = overflow_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (octets.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.store_char)
        begin
            if (count_reg < LABEL_LIMIT)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.start_run)
        begin
            idx_next = '0;
        end
        if (cmd.load_octet)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (last_octet)
            begin
                count_next = '0;
                if (at_end_reg)
                begin
                    total_next    = '0;
                    overflow_next = 1'b0;
                end
                else
                begin
                    total_next = run_total_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            overflow_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            overflow_reg  <= overflow_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // run context, latched when a separator or end of name arrives
    always_ff @(posedge clk)
    begin
        if (cmd.start_run)
        begin
            at_end_reg    <= mode;
            run_total_reg <= total_sat;
            name_len_reg  <= (mode == MODE_END) ? name_sat : '0;
        end
    end

    // label store: written at the fill point, read one octet ahead of the output
    always_ff @(posedge clk)
    begin
        if (cmd.store_char && (count_reg < LABEL_LIMIT))
        begin
            store_mem[count_reg] <= octet;
        end
        if (cmd.load_octet && !last_octet)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_octet)
        begin
            out_octet_reg <= (idx_reg == '0) ? {2'b00, count_reg} : rd_data_reg;
            out_last_reg  <= last_octet;
            out_end_reg   <= at_end_reg;
            out_len_reg   <= name_len_reg;
            out_ovf_reg   <= overflow_reg;
        end
    end

    assign octets.valid          = out_valid_reg;
    assign octets.out_octet      = out_octet_reg;
    assign octets.run_last       = out_last_reg;
    assign octets.name_end       = out_end_reg;
    assign octets.name_length    = out_len_reg;
    assign octets.label_overflow = out_ovf_reg;

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LABEL_LIMIT)
        else $error("label count beyond limit");

    a_name_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_octet && last_octet && at_end_reg
        |=> total_reg == '0 && !overflow_reg && count_reg == '0)
        else $error("name state not cleared after end of name");

    a_name_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_len_reg >= 9'd2)
        else $error("name length too short at end of name");

    a_length_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_octet && idx_reg == '0 |=> out_octet_reg == {2'b00, $past(count_reg)})
        else $error("run does not open with the label length");

endmodule

>>> hw/rtl/dnle_controller.sv
// sequencing of buffering and label emission
module dnle_controller
    import dnle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  dnle_status_t status,
    output logic         in_ready,
    output dnle_cmd_t    cmd
);

    dnle_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.store_char = 1'b0;
        cmd.start_run  = 1'b0;
        cmd.load_octet = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.run_item)
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        cmd.store_char = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_octet = 1'b1;
                    if (status.last_octet)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_store_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !cmd.store_char && !cmd.start_run)
        else $error("transaction taken during label emission");

    a_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_run |=> state_reg == ST_EMIT)
        else $error("run start did not enter emission");

    a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_octet && status.last_octet |=> state_reg == ST_IDLE)
        else $error("emission did not end on the last octet");

endmodule

>>> hw/rtl/dns_name_label_encoder.sv
// A dotted name enters one character per transaction and leaves in DNS wire form: each label
// as a length octet followed by its characters. An ordinary character is only buffered; a
// '.' or end of name latches the run, then its length octet and characters leave at one
// octet per cycle while the output is free, from the single read port of the label store, and
// no new character is taken until the run has been handed over. Labels are truncated at 63
// characters with label_overflow set; the zero terminator is not sent, name_end and
// name_length (saturating at 511) announce it. Output stalls hold the run in place.
module dns_name_label_encoder
    import dnle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dnle_in_if.sink   chars,
    dnle_out_if.source octets
);

    dnle_cmd_t    cmd;
    dnle_status_t status;

    dnle_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .status   (status),
        .in_ready (chars.ready),
        .cmd      (cmd)
    );

    dnle_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (chars.mode),
        .octet  (chars.octet),
        .cmd    (cmd),
        .status (status),
        .octets (octets)
    );

endmodule
